// ===== rtl/dwgf_pkg.sv =====
// Shared constants, codes and the sequencer state type of the densest window group finder.
package dwgf_pkg;

  localparam int MaxSignatures = 4096;
  localparam int AddrW         = $clog2(MaxSignatures);
  localparam int CntW          = $clog2(MaxSignatures + 1);

  localparam int PosW     = 31;
  localparam int StartW   = 12;
  localparam int ActW     = 2;
  localparam int StatW    = 2;
  localparam int FirstW   = 12;
  localparam int IdxW     = 13;
  localparam int GnumW    = 32;
  localparam int WinW     = 10;
  localparam int DistW    = 10;
  localparam int MinW     = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Window bounds can run a little past the largest position while sliding.
  localparam int WinPosW = 32;
  localparam int AluW    = WinPosW + 2;

  localparam int InDataW  = 48;
  localparam int InUserW  = 2;
  localparam int OutUsedW = StatW + 1 + FirstW + IdxW + GnumW + IdxW;
  localparam int OutDataW = 80;
  localparam int OutPadW  = OutDataW - OutUsedW;

  localparam logic [ActW-1:0] ActAppend = 2'd0;
  localparam logic [ActW-1:0] ActFind   = 2'd1;
  localparam logic [ActW-1:0] ActClear  = 2'd2;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatFull     = 2'd1;
  localparam logic [StatW-1:0] StatBadStart = 2'd2;

  localparam logic [CfgIdxW-1:0] RegWindowLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDistance  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinGroupSize = 2'd2;

  localparam logic [WinW-1:0]  WindowLengthRst = 10'd10;
  localparam logic [DistW-1:0] MaxDistanceRst  = 10'd20;
  localparam logic [MinW-1:0]  MinGroupSizeRst = 13'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_RD0,
    ST_A_EV0,
    ST_A_CHK,
    ST_A_EV,
    ST_A_DONE,
    ST_B_CHK,
    ST_B_DRD,
    ST_B_DEV,
    ST_B_ARD,
    ST_B_AEV,
    ST_B_END,
    ST_B_BEST,
    ST_C_RD0,
    ST_C_EV0,
    ST_C_BCHK,
    ST_C_BEV,
    ST_C_FCHK,
    ST_C_FEV,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/densest_window_group_finder.sv =====
// Densest window group finder: position store, search sequencer and shared compare unit.
// Append, clear and rejected finds go from idle to ST_OUT, which loads the output register
// once the output is free. A find reads positions through the single registered memory
// port (initial window, each slide's rescan of the window and its new members, and the
// backward and forward widening) and sets its result in ST_FIN before ST_OUT.
// Throughput: one word at a time; s_axis_tready is high only while the sequencer is idle.
// Reset clears the count, the group counter and the output valid and restores the registers.
module densest_window_group_finder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: position [30:0], start_index [42:31], zero fill [47:43].
  input  logic [dwgf_pkg::InDataW-1:0]     s_axis_tdata,
  // Fields from bit 0 up: action [1:0].
  input  logic [dwgf_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: status [1:0], group_found [2], first_index [14:3],
  // end_index [27:15], group_number [59:28], next_index [72:60], zero fill [79:73].
  output logic [dwgf_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dwgf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dwgf_pkg::CfgDataW-1:0]    cfg_data_i
);
  import dwgf_pkg::*;

  state_e state_q, state_d;

  // Configuration and persistent state.
  logic [WinW-1:0]  win_len_q;
  logic [DistW-1:0] max_dist_q;
  logic [MinW-1:0]  min_size_q;
  logic [CntW-1:0]  count_q;
  logic [GnumW-1:0] group_ctr_q;

  // Position store with one write port and one registered read port.
  logic [PosW-1:0]  pos_mem_q [MaxSignatures];
  logic [PosW-1:0]  rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;

  // Search working registers.
  logic [CntW-1:0]    start_q, lo_q, hi_q, k_q, drop_q, best_q, centre_q, gfrom_q, gto_q;
  logic [WinPosW-1:0] woff_q, wend_q;
  logic [PosW-1:0]    cpos_q;

  // Finished result waiting for the output register.
  logic [StatW-1:0]  res_status_q;
  logic              res_found_q;
  logic [FirstW-1:0] res_first_q;
  logic [IdxW-1:0]   res_end_q;
  logic [GnumW-1:0]  res_gnum_q;
  logic [IdxW-1:0]   res_next_q;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  // Input decode.
  logic [ActW-1:0]   in_action;
  logic [PosW-1:0]   in_pos;
  logic [StartW-1:0] in_start;
  logic              accept;
  logic              list_full;
  logic              bad_start;
  logic [StatW-1:0]  status_now;
  logic              out_free;

  assign in_action = s_axis_tuser[ActW-1:0];
  assign in_pos    = s_axis_tdata[PosW-1:0];
  assign in_start  = s_axis_tdata[PosW +: StartW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign list_full = (count_q >= CntW'(MaxSignatures));
  assign bad_start = (CntW'(in_start) >= count_q);
  assign mem_we    = accept && (in_action == ActAppend) && !list_full;

  always_comb begin
    status_now = StatOk;
    if ((in_action == ActAppend) && list_full) begin
      status_now = StatFull;
    end else if ((in_action == ActFind) && bad_start) begin
      status_now = StatBadStart;
    end
  end

  // Shared add/subtract unit; every position compare of the search goes through it.
  logic [AluW-2:0] alu_a, alu_b;
  logic            alu_sub;
  logic [AluW-1:0] alu_res;
  logic            alu_neg, alu_zero, alu_near;

  assign alu_res  = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                            : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_neg  = alu_res[AluW-1];
  assign alu_zero = (alu_res == '0);
  // Signed test, so a negative distance counts as near.
  assign alu_near = ($signed(alu_res) <= $signed(AluW'(max_dist_q)));

  // Index arithmetic.
  logic [CntW-1:0]    span, k_inc, gfrom_dec, gsize;
  logic [WinPosW-1:0] wend_inc;
  logic               found_now;

  assign span      = hi_q - lo_q;
  assign k_inc     = k_q + CntW'(1);
  assign gfrom_dec = gfrom_q - CntW'(1);
  assign gsize     = gto_q - gfrom_q;
  assign wend_inc  = wend_q + WinPosW'(1);
  assign found_now = (32'(gsize) >= 32'(min_size_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((in_action == ActFind) && !bad_start) begin
            state_d = ST_A_RD0;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_A_RD0:  state_d = ST_A_EV0;
      ST_A_EV0:  state_d = ST_A_CHK;
      ST_A_CHK:  state_d = (hi_q < count_q) ? ST_A_EV : ST_A_DONE;
      ST_A_EV:   state_d = alu_neg ? ST_A_CHK : ST_A_DONE;
      ST_A_DONE: state_d = ST_B_CHK;
      ST_B_CHK:  state_d = (hi_q < count_q) ? ST_B_DRD : ST_C_RD0;
      ST_B_DRD:  state_d = ST_B_DEV;
      ST_B_DEV:  state_d = (k_inc == hi_q) ? ST_B_ARD : ST_B_DRD;
      ST_B_ARD:  state_d = (k_q < count_q) ? ST_B_AEV : ST_B_END;
      ST_B_AEV:  state_d = alu_zero ? ST_B_ARD : ST_B_END;
      ST_B_END:  state_d = (k_q == hi_q) ? ST_C_RD0 : ST_B_BEST;
      ST_B_BEST: state_d = ST_B_CHK;
      ST_C_RD0:  state_d = ST_C_EV0;
      ST_C_EV0:  state_d = ST_C_BCHK;
      ST_C_BCHK: state_d = (gfrom_q > start_q) ? ST_C_BEV : ST_C_FCHK;
      ST_C_BEV:  state_d = alu_near ? ST_C_BCHK : ST_C_FCHK;
      ST_C_FCHK: state_d = (gto_q < count_q) ? ST_C_FEV : ST_FIN;
      ST_C_FEV:  state_d = alu_near ? ST_C_FCHK : ST_FIN;
      ST_FIN:    state_d = ST_OUT;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory address and compare unit operands for each step.
  always_comb begin
    rd_addr = hi_q[AddrW-1:0];
    alu_a   = (AluW-1)'(rd_data_q);
    alu_b   = (AluW-1)'(wend_q);
    alu_sub = 1'b1;
    unique case (state_q)
      ST_A_RD0: rd_addr = start_q[AddrW-1:0];
      ST_A_EV0: begin
        // Window end is the first position plus the window length.
        alu_b   = (AluW-1)'(win_len_q);
        alu_sub = 1'b0;
      end
      ST_B_DRD:  rd_addr = k_q[AddrW-1:0];
      ST_B_DEV:  alu_b = (AluW-1)'(woff_q);
      ST_B_ARD:  rd_addr = k_q[AddrW-1:0];
      ST_B_AEV:  alu_b = (AluW-1)'(wend_inc);
      ST_C_RD0:  rd_addr = centre_q[AddrW-1:0];
      ST_C_BCHK: rd_addr = gfrom_dec[AddrW-1:0];
      ST_C_BEV: begin
        alu_a = (AluW-1)'(cpos_q);
        alu_b = (AluW-1)'(rd_data_q);
      end
      ST_C_FCHK: rd_addr = gto_q[AddrW-1:0];
      ST_C_FEV:  alu_b = (AluW-1)'(cpos_q);
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= WindowLengthRst;
      max_dist_q  <= MaxDistanceRst;
      min_size_q  <= MinGroupSizeRst;
      count_q     <= '0;
      group_ctr_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegWindowLength: win_len_q  <= cfg_data_i[WinW-1:0];
          RegMaxDistance:  max_dist_q <= cfg_data_i[DistW-1:0];
          RegMinGroupSize: min_size_q <= cfg_data_i[MinW-1:0];
          default: ;
        endcase
      end
      if (mem_we) begin
        count_q <= count_q + CntW'(1);
      end
      if (accept && (in_action == ActClear)) begin
        count_q     <= '0;
        group_ctr_q <= '0;
      end
      if ((state_q == ST_FIN) && found_now) begin
        group_ctr_q <= group_ctr_q + GnumW'(1);
      end
      if ((state_q == ST_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem_q[count_q[AddrW-1:0]] <= in_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= pos_mem_q[rd_addr];
  end

  // Search datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          start_q      <= CntW'(in_start);
          lo_q         <= CntW'(in_start);
          hi_q         <= CntW'(in_start) + CntW'(1);
          res_status_q <= status_now;
          res_found_q  <= 1'b0;
          res_first_q  <= '0;
          res_end_q    <= '0;
          res_gnum_q   <= '0;
          res_next_q   <= '0;
        end
      end
      ST_A_EV0: begin
        woff_q <= WinPosW'(rd_data_q);
        wend_q <= alu_res[WinPosW-1:0];
      end
      ST_A_EV: begin
        if (alu_neg) begin
          hi_q <= hi_q + CntW'(1);
        end
      end
      ST_A_DONE: begin
        best_q   <= span;
        centre_q <= lo_q + (span >> 1);
      end
      ST_B_CHK: begin
        k_q    <= lo_q;
        drop_q <= '0;
      end
      ST_B_DEV: begin
        if (alu_zero) begin
          drop_q <= drop_q + CntW'(1);
        end
        k_q <= k_inc;
      end
      ST_B_AEV: begin
        if (alu_zero) begin
          k_q <= k_inc;
        end
      end
      ST_B_END: begin
        // The slide only happens when at least one member joined at the new end.
        if (k_q != hi_q) begin
          lo_q   <= lo_q + drop_q;
          hi_q   <= k_q;
          woff_q <= woff_q + WinPosW'(1);
          wend_q <= wend_inc;
        end
      end
      ST_B_BEST: begin
        if (span > best_q) begin
          best_q   <= span;
          centre_q <= lo_q + (span >> 1);
        end
      end
      ST_C_EV0: begin
        cpos_q  <= rd_data_q;
        gfrom_q <= centre_q;
        gto_q   <= centre_q + CntW'(1);
      end
      ST_C_BEV: begin
        if (alu_near) begin
          gfrom_q <= gfrom_dec;
        end
      end
      ST_C_FEV: begin
        if (alu_near) begin
          gto_q <= gto_q + CntW'(1);
        end
      end
      ST_FIN: begin
        res_found_q <= found_now;
        res_gnum_q  <= found_now ? group_ctr_q : '0;
        res_first_q <= FirstW'(gfrom_q);
        res_end_q   <= IdxW'(gto_q);
        res_next_q  <= IdxW'(gto_q);
      end
      ST_OUT: begin
        if (out_free) begin
          m_data_q <= {{OutPadW{1'b0}}, res_next_q, res_gnum_q, res_end_q,
                       res_first_q, res_found_q, res_status_q};
        end
      end
      default: ;
    endcase
  end

  // The list never grows past the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSignatures))
    else $error("signature count beyond store depth");

  // The sliding window always holds at least one member while it is rescanned.
  a_window_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B_CHK || state_q == ST_B_DRD || state_q == ST_B_DEV) |-> (lo_q < hi_q))
    else $error("empty sliding window");

  // The centre member lies inside the stored list and not before the start index.
  a_centre_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_C_RD0) |-> (centre_q < count_q && centre_q >= start_q))
    else $error("centre index out of range");

  // A numbered group advances the group counter by exactly one.
  a_group_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && found_now) |=> (group_ctr_q == $past(group_ctr_q) + GnumW'(1)))
    else $error("group counter did not advance");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking stream testbench for the densest window group finder.
`timescale 1ns / 100ps

module tb_top;
  import dwgf_pkg::*;

  // Action 3 is decoded as a no-op; register index 3 selects no register.
  localparam logic [ActW-1:0]    ActNone   = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [ActW-1:0]   act;
    logic [PosW-1:0]   pos;
    logic [StartW-1:0] start;
    bit                drain;
  } req_t;

  // Same layout as the used low bits of m_axis_tdata, highest field first.
  typedef struct packed {
    logic [IdxW-1:0]   next_idx;
    logic [GnumW-1:0]  group_num;
    logic [IdxW-1:0]   end_idx;
    logic [FirstW-1:0] first_idx;
    logic              found;
    logic [StatW-1:0]  status;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  densest_window_group_finder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow of the block's state and registers.
  logic [PosW-1:0] sig_pos [MaxSignatures];
  int unsigned     sig_count = 0;
  logic [GnumW-1:0] group_ctr = '0;
  int unsigned     win_len  = WindowLengthRst;
  int unsigned     max_dist = MaxDistanceRst;
  int unsigned     min_size = MinGroupSizeRst;

  req_t        request_queue[$];
  outcome_t    awaited_outcomes[$];
  req_t        offered;
  int unsigned words_sent  = 0;
  int unsigned words_taken = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned hold_cycles = 0;
  bit          idle_send = 1'b1;
  bit          idle_sink = 1'b1;

  // Stimulus bookkeeping: list length as the generator sees it, and
  // counted words of the current phase.
  int unsigned gen_count   = 0;
  int unsigned phase_items = 0;

  // Applies one accepted word to the shadow state and returns the result word.
  function automatic outcome_t finder_outcome(req_t r);
    outcome_t    o;
    int unsigned n, lo, hi, k, cnt, best, centre, gfrom, gto, dropped, added;
    longint      woff, wend, cpos;
    o = '0;
    case (r.act)
      ActAppend: begin
        if (sig_count >= MaxSignatures) begin
          o.status = StatFull;
        end else begin
          sig_pos[sig_count] = r.pos;
          sig_count++;
        end
      end
      ActClear: begin
        sig_count = 0;
        group_ctr = '0;
      end
      ActFind: begin
        n = sig_count;
        if (r.start >= n) begin
          o.status = StatBadStart;
        end else begin
          lo   = 32'(r.start);
          hi   = lo + 1;
          woff = longint'(sig_pos[lo]);
          wend = woff + longint'(win_len);
          while (hi < n && longint'(sig_pos[hi]) < wend) hi++;
          cnt    = hi - lo;
          best   = cnt;
          centre = lo + cnt / 2;
          // Slide one position at a time, only while the next member sits
          // exactly one past the window end.
          while (hi < n) begin
            dropped = 0;
            added   = 0;
            for (k = lo; k < hi; k++)
              if (longint'(sig_pos[k]) == woff) dropped++;
            k = hi;
            while (k < n && longint'(sig_pos[k]) == wend + 1) begin
              added++;
              k++;
            end
            if (added == 0) break;
            cnt = cnt - dropped + added;
            woff++;
            wend++;
            lo += dropped;
            hi = k;
            if (cnt > best) begin
              best   = cnt;
              centre = lo + cnt / 2;
            end
          end
          // Widen around the centre; signed distances, so members below the
          // centre on an unsorted list always pass the forward test.
          cpos  = longint'(sig_pos[centre]);
          gfrom = centre;
          while (gfrom > r.start &&
                 cpos - longint'(sig_pos[gfrom-1]) <= longint'(max_dist)) gfrom--;
          gto = centre + 1;
          while (gto < n && longint'(sig_pos[gto]) - cpos <= longint'(max_dist)) gto++;
          if (gto - gfrom >= min_size) begin
            o.found     = 1'b1;
            o.group_num = group_ctr;
            group_ctr++;
          end
          o.first_idx = gfrom[FirstW-1:0];
          o.end_idx   = gto[IdxW-1:0];
          o.next_idx  = gto[IdxW-1:0];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void push_word(input logic [ActW-1:0] act, input int unsigned pos,
                                    input int unsigned start, input bit drain = 1'b0);
    req_t r;
    r.act   = act;
    r.pos   = pos[PosW-1:0];
    r.start = start[StartW-1:0];
    r.drain = drain;
    request_queue.push_back(r);
    words_sent++;
    if (act != ActNone) phase_items++;
  endfunction

  // One list (mostly sorted, runs of equal and consecutive positions so that
  // the window slides) followed by a few finds and some noise.
  function automatic void queue_batch();
    int unsigned len, nfind, base, p, i, start;
    bit          jumbled;
    if (gen_count > 150 || $urandom_range(0, 9) < 8) begin
      push_word(ActClear, $urandom(), $urandom());
      gen_count = 0;
    end
    len     = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    jumbled = ($urandom_range(0, 9) == 0);
    base    = $urandom_range(0, 32'h7FFF_0000);
    p       = base;
    for (i = 0; i < len; i++) begin
      if (jumbled) begin
        p = base + $urandom_range(0, 60);
      end else begin
        case ($urandom_range(0, 9))
          0, 1:       p = p;
          2, 3, 4, 5: p = p + 1;
          6, 7:       p = p + $urandom_range(2, 3);
          default:    p = p + $urandom_range(0, 40);
        endcase
      end
      push_word(ActAppend, p, $urandom());
      if ($urandom_range(0, 29) == 0) push_word(ActNone, $urandom(), $urandom());
    end
    gen_count = (gen_count + len > MaxSignatures) ? MaxSignatures : gen_count + len;
    nfind = $urandom_range(1, 6);
    for (i = 0; i < nfind; i++) begin
      case ($urandom_range(0, 9))
        0:       start = 0;
        1:       start = (gen_count < MaxSignatures) ? $urandom_range(gen_count, 4095) : 0;
        default: start = $urandom_range(0, gen_count - 1);
      endcase
      push_word(ActFind, $urandom(), start, (i == 0) && ($urandom_range(0, 24) == 0));
    end
  endfunction

  // Block is idle once every queued word was taken and every result came back.
  task automatic wait_drained();
    while (words_taken != words_sent || awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (!cfg_valid_i) cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegWindowLength: win_len  = 32'(val[WinW-1:0]);
      RegMaxDistance:  max_dist = 32'(val[DistW-1:0]);
      RegMinGroupSize: min_size = 32'(val[MinW-1:0]);
      default: ;
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: offers the next word after its drawn gap; a word marked drain is
  // held back until every result in flight has come back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_outcomes.push_back(finder_outcome(offered));
        words_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].drain && awaited_outcomes.size() != 0)) begin
          offered = request_queue.pop_front();
          s_axis_tdata  <= {{(InDataW - StartW - PosW){1'b0}}, offered.start, offered.pos};
          s_axis_tuser  <= offered.act;
          s_axis_tvalid <= 1'b1;
          send_gap = idle_send ? $urandom_range(0, 15) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    outcome_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutUsedW-1:0];
        if (awaited_outcomes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result word with nothing pending: %h", $realtime, m_axis_tdata);
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.first_idx !== want.first_idx || got.end_idx !== want.end_idx ||
              got.group_num !== want.group_num || got.next_idx !== want.next_idx) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("%0t: mismatch (exp/got) status %0d/%0d found %0d/%0d ",
                     $realtime, want.status, got.status, want.found, got.found);
              $display("first %0d/%0d end %0d/%0d group %0d/%0d next %0d/%0d",
                       want.first_idx, got.first_idx, want.end_idx, got.end_idx,
                       want.group_num, got.group_num, want.next_idx, got.next_idx);
            end
          end
        end
        hold_cycles = idle_sink ? $urandom_range(0, 15) : 0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      m_axis_tready <= (hold_cycles == 0);
    end
  end

  initial begin
    int unsigned seed_pos[12];
    int unsigned win_set[12], dist_set[12], min_set[12];
    int unsigned i, base;
    seed_pos = '{0, 5, 6, 7, 8, 9, 11, 12, 13, 30, 32'h7FFF_FFFF, 40};
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed words at reset settings: find on an empty list, the no-op
    // action, a list whose window slides three times, the largest position
    // followed by an out-of-order one, a start past the count, and a clear.
    push_word(ActFind, 0, 0);
    push_word(ActNone, 32'h7FFF_FFFF, 4095);
    for (i = 0; i < 12; i++) push_word(ActAppend, seed_pos[i], 4095);
    push_word(ActFind, 32'h7FFF_FFFF, 0);
    push_word(ActFind, 0, 6);
    push_word(ActFind, 0, 10);
    push_word(ActFind, 0, 11);
    push_word(ActFind, 0, 4095);
    push_word(ActClear, 0, 0);
    push_word(ActFind, 0, 0);
    wait_drained();

    // Register settings: the extremes and one mid set first, then random ones.
    win_set[0] = 1;    dist_set[0] = 0;    min_set[0] = 1;
    win_set[1] = 1023; dist_set[1] = 1023; min_set[1] = 4096;
    win_set[2] = 0;    dist_set[2] = 0;    min_set[2] = 0;
    win_set[3] = 1023; dist_set[3] = 0;    min_set[3] = 8191;
    win_set[4] = 3;    dist_set[4] = 5;    min_set[4] = 2;
    for (i = 5; i < 12; i++) begin
      win_set[i]  = $urandom_range(1, 40);
      dist_set[i] = $urandom_range(0, 80);
      min_set[i]  = $urandom_range(1, 10);
    end

    for (i = 0; i < 12; i++) begin
      // Upper data bits are don't-care for the 10-bit registers.
      write_reg(RegWindowLength, {3'($urandom()), 10'(win_set[i])});
      write_reg(RegMaxDistance, {3'($urandom()), 10'(dist_set[i])});
      write_reg(RegMinGroupSize, 13'(min_set[i]));
      if (i == 1) write_reg(RegUnused, 13'($urandom()));
      cfg_valid_i <= 1'b0;
      idle_send   = (i % 4 != 2);
      idle_sink   = (i % 4 != 3);
      phase_items = 0;
      while (phase_items < 120) queue_batch();
      wait_drained();
    end

    // Full list: fill every entry, then one append too many, then finds that
    // reach the top of the start index range.
    write_reg(RegWindowLength, 13'd10);
    write_reg(RegMaxDistance, 13'd200);
    write_reg(RegMinGroupSize, 13'd3);
    cfg_valid_i <= 1'b0;
    idle_send = 1'b1;
    idle_sink = 1'b1;
    push_word(ActClear, 0, 0);
    base = $urandom_range(0, 32'h7FF0_0000);
    for (i = 0; i < MaxSignatures; i++)
      push_word(ActAppend, base + i * 64 + $urandom_range(0, 3), $urandom());
    push_word(ActAppend, $urandom(), $urandom());
    push_word(ActFind, $urandom(), 0);
    push_word(ActFind, $urandom(), 4095);
    push_word(ActFind, $urandom(), 2048);
    push_word(ActFind, $urandom(), 2047, 1'b1);
    for (i = 0; i < 6; i++) push_word(ActFind, $urandom(), $urandom());
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && awaited_outcomes.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #60_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
